// ===== rtl/hufd_pkg.sv =====
// Package for the Huffman tree bitstream decoder: widths, codes and shared types.
// No dependencies; compiled first.
`default_nettype none
package hufd_pkg;

  localparam int TREE_BYTES_DEF = 512;
  localparam int IDX_W          = 9;
  localparam int BYTE_W         = 8;
  localparam int NIB_W          = 4;
  localparam int WORD_W         = 32;
  localparam int LEN_W          = 24;
  localparam int BITCNT_W       = 6;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NIBBLE_SYMBOLS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_LENGTH     = 1'd1;

  // input transaction kinds
  localparam logic KIND_TREE = 1'b0;
  localparam logic KIND_WORD = 1'b1;

  localparam logic [IDX_W-1:0]    ROOT_IDX   = 9'd1;
  localparam logic [BITCNT_W-1:0] WORD_BITS  = 6'd32;

  typedef struct packed {
    logic [IDX_W-1:0] next_idx;
    logic             leaf;
  } step_res_t;

endpackage
`default_nettype wire

// ===== rtl/hufd_in_if.sv =====
// Input channel: tree byte loads and bitstream words.
// Depends on hufd_pkg.
`default_nettype none
interface hufd_in_if;
  import hufd_pkg::*;
  logic                valid;
  logic                ready;
  logic                kind;
  logic [IDX_W-1:0]    tree_index;
  logic [BYTE_W-1:0]   tree_byte;
  logic [WORD_W-1:0]   stream_word;

  modport source (output valid, kind, tree_index, tree_byte, stream_word, input ready);
  modport sink   (input valid, kind, tree_index, tree_byte, stream_word, output ready);
endinterface
`default_nettype wire

// ===== rtl/hufd_out_if.sv =====
// Result channel: decoded bytes with end-of-word and end-of-run flags.
// Depends on hufd_pkg.
`default_nettype none
interface hufd_out_if;
  import hufd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              run_last;
  logic              finished;

  modport source (output valid, out_byte, run_last, finished, input ready);
  modport sink   (input valid, out_byte, run_last, finished, output ready);
endinterface
`default_nettype wire

// ===== rtl/hufd_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on hufd_pkg.
`default_nettype none
interface hufd_cfg_if;
  import hufd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/huffman_tree_bitstream_decoder_top.sv =====
// Huffman tree bitstream decoder, top level. Depends on hufd_pkg, the channel
// interfaces, hufd_ram and hufd_step.
// A tree byte transaction is taken while idle. A word is accepted, then each branch bit
// takes a node read and each leaf bit a node read, then a leaf read through the single
// tree RAM read port, before a closing state; the walk stops early once the output length
// is met, and stalls when the result side cannot take a byte. No new transaction is taken
// until the word is done. A decoded byte is held until the next byte of its word or the
// closing state, then shows on out_ch. Reset (rst_n low, synchronous) returns the walk to
// the root and clears the output count, config and valid flags; tree RAM contents are not cleared.
`default_nettype none
module huffman_tree_bitstream_decoder_top #(
  parameter int TREE_BYTES = hufd_pkg::TREE_BYTES_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  hufd_in_if.sink     in_ch,
  hufd_out_if.source  out_ch,
  hufd_cfg_if.sink    cfg_ch
);
  import hufd_pkg::*;

  localparam int AW = $clog2(TREE_BYTES);
  localparam logic [IDX_W:0] TREE_LIM = (IDX_W+1)'(TREE_BYTES);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a transaction
  localparam logic [1:0] S_NODE = 2'd1;  // node byte on RAM output
  localparam logic [1:0] S_LEAF = 2'd2;  // leaf value on RAM output
  localparam logic [1:0] S_END  = 2'd3;  // flush held byte as last of word

  logic [1:0]          state_r, state_nxt;
  logic [IDX_W-1:0]    node_idx_r, node_idx_nxt;
  logic [NIB_W-1:0]    partial_r, partial_nxt;
  logic                slot_r, slot_nxt;
  logic [LEN_W-1:0]    bytes_done_r, bytes_done_nxt;
  logic                nibble_r, nibble_nxt;
  logic [LEN_W-1:0]    out_len_r, out_len_nxt;
  logic [WORD_W-1:0]   word_r, word_nxt;
  logic [BITCNT_W-1:0] bits_left_r, bits_left_nxt;
  logic                oor_r, oor_nxt;
  // held byte: newest decoded byte, not yet known whether it ends the word
  logic                hold_v_r, hold_v_nxt;
  logic [BYTE_W-1:0]   hold_byte_r, hold_byte_nxt;
  logic                hold_fin_r, hold_fin_nxt;
  // output register
  logic                out_v_r, out_v_nxt;
  logic [BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_fin_r, out_fin_nxt;

  logic                in_fire;
  logic                out_free;
  logic                ram_we;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_idx;
  logic [BYTE_W-1:0]   ram_q;
  logic [BYTE_W-1:0]   rd_byte;
  step_res_t           step;
  logic                len_met;
  logic                emit;
  logic [BYTE_W-1:0]   sym_byte;
  logic [LEN_W-1:0]    bd_inc;

  assign in_ch.ready   = (state_r == S_IDLE);
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid    = out_v_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.run_last = out_last_r;
  assign out_ch.finished = out_fin_r;
  assign out_free      = !out_v_r || out_ch.ready;

  // tree store; writes beyond TREE_BYTES are dropped, reads there give zero
  assign ram_we = in_fire && (in_ch.kind == KIND_TREE)
               && ({1'b0, in_ch.tree_index} < TREE_LIM);

  hufd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TREE_BYTES)
  ) u_tree_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (in_ch.tree_index[AW-1:0]),
    .wdata   (in_ch.tree_byte),
    .re      (rd_en),
    .raddr   (rd_idx[AW-1:0]),
    .rdata_r (ram_q)
  );

  assign rd_byte = oor_r ? '0 : ram_q;

  hufd_step u_step (
    .node_idx  (node_idx_r),
    .node_byte (rd_byte),
    .bit_in    (word_r[WORD_W-1]),
    .res       (step)
  );

  assign len_met  = (bytes_done_r >= out_len_r);
  assign emit     = nibble_r ? slot_r : 1'b1;
  assign sym_byte = nibble_r ? {rd_byte[NIB_W-1:0], partial_r} : rd_byte;
  assign bd_inc   = bytes_done_r + LEN_W'(1);

  always_comb begin
    state_nxt      = state_r;
    node_idx_nxt   = node_idx_r;
    partial_nxt    = partial_r;
    slot_nxt       = slot_r;
    bytes_done_nxt = bytes_done_r;
    nibble_nxt     = nibble_r;
    out_len_nxt    = out_len_r;
    word_nxt       = word_r;
    bits_left_nxt  = bits_left_r;
    hold_v_nxt     = hold_v_r;
    hold_byte_nxt  = hold_byte_r;
    hold_fin_nxt   = hold_fin_r;
    out_v_nxt      = out_v_r && !out_ch.ready;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_fin_nxt    = out_fin_r;
    rd_en          = 1'b0;
    rd_idx         = node_idx_r;

    // the user must write config only while idle; the block itself does not enforce it
    if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        CFG_NIBBLE_SYMBOLS: nibble_nxt  = cfg_ch.data[0];
        CFG_OUT_LENGTH:     out_len_nxt = cfg_ch.data[LEN_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_ch.kind == KIND_WORD)) begin
          word_nxt      = in_ch.stream_word;
          bits_left_nxt = WORD_BITS;
          if (len_met) begin
            state_nxt = S_END;
          end else begin
            rd_en     = 1'b1;
            rd_idx    = node_idx_r;
            state_nxt = S_NODE;
          end
        end
      end

      S_NODE: begin
        node_idx_nxt = step.next_idx;
        if (step.leaf) begin
          // fetch the leaf value; bit is consumed in S_LEAF
          rd_en     = 1'b1;
          rd_idx    = step.next_idx;
          state_nxt = S_LEAF;
        end else begin
          word_nxt      = {word_r[WORD_W-2:0], 1'b0};
          bits_left_nxt = bits_left_r - BITCNT_W'(1);
          if (bits_left_r == BITCNT_W'(1)) begin
            state_nxt = S_END;
          end else begin
            rd_en  = 1'b1;
            rd_idx = step.next_idx;
          end
        end
      end

      S_LEAF: begin
        // stall only if a byte must move into a full output register
        if (!(emit && hold_v_r && !out_free)) begin
          node_idx_nxt  = ROOT_IDX;
          word_nxt      = {word_r[WORD_W-2:0], 1'b0};
          bits_left_nxt = bits_left_r - BITCNT_W'(1);
          if (nibble_r) begin
            partial_nxt = slot_r ? '0 : rd_byte[NIB_W-1:0];
            slot_nxt    = !slot_r;
          end
          if (emit) begin
            bytes_done_nxt = bd_inc;
            hold_v_nxt     = 1'b1;
            hold_byte_nxt  = sym_byte;
            hold_fin_nxt   = (bd_inc == out_len_r);
            if (hold_v_r) begin
              out_v_nxt    = 1'b1;
              out_byte_nxt = hold_byte_r;
              out_last_nxt = 1'b0;
              out_fin_nxt  = hold_fin_r;
            end
          end
          if ((bits_left_r == BITCNT_W'(1)) || ((emit ? bd_inc : bytes_done_r) >= out_len_r))
          begin
            state_nxt = S_END;
          end else begin
            rd_en     = 1'b1;
            rd_idx    = ROOT_IDX;
            state_nxt = S_NODE;
          end
        end
      end

      S_END: begin
        if (len_met) begin
          node_idx_nxt = ROOT_IDX;
        end
        if (!hold_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_v_nxt    = 1'b1;
          out_byte_nxt = hold_byte_r;
          out_last_nxt = 1'b1;
          out_fin_nxt  = hold_fin_r;
          hold_v_nxt   = 1'b0;
          state_nxt    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    oor_nxt = rd_en ? !({1'b0, rd_idx} < TREE_LIM) : oor_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_idx_r   <= ROOT_IDX;
      partial_r    <= '0;
      slot_r       <= 1'b0;
      bytes_done_r <= '0;
      nibble_r     <= 1'b0;
      out_len_r    <= '0;
      hold_v_r     <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      node_idx_r   <= node_idx_nxt;
      partial_r    <= partial_nxt;
      slot_r       <= slot_nxt;
      bytes_done_r <= bytes_done_nxt;
      nibble_r     <= nibble_nxt;
      out_len_r    <= out_len_nxt;
      hold_v_r     <= hold_v_nxt;
      out_v_r      <= out_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    word_r      <= word_nxt;
    bits_left_r <= bits_left_nxt;
    oor_r       <= oor_nxt;
    hold_byte_r <= hold_byte_nxt;
    hold_fin_r  <= hold_fin_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    out_fin_r   <= out_fin_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/hufd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module hufd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hufd_step.sv =====
// Tree walk step: next node index and leaf flag for one stream bit.
// Depends on hufd_pkg.
`default_nettype none
module hufd_step (
  input  wire logic [hufd_pkg::IDX_W-1:0]  node_idx,
  input  wire logic [hufd_pkg::BYTE_W-1:0] node_byte,
  input  wire logic                        bit_in,
  output hufd_pkg::step_res_t              res
);
  import hufd_pkg::*;

  // (idx & ~1) + offset*2 + 2 + bit, wrapping at 9 bits
  always_comb begin
    res.next_idx = {node_idx[IDX_W-1:1], 1'b0}
                 + {{(IDX_W-7){1'b0}}, node_byte[5:0], 1'b0}
                 + IDX_W'(2)
                 + {{(IDX_W-1){1'b0}}, bit_in};
    res.leaf     = bit_in ? node_byte[6] : node_byte[7];
  end

endmodule
`default_nettype wire
